// ===== sv/bbwst_pkg.sv =====
`default_nettype none

package bbwst_pkg;

  localparam int ADC_BITS_DEF = 12;

  localparam int SMP_FIELD_W = 12;
  localparam int TIME_W      = 32;
  localparam int THR_W       = 13;
  localparam int IND_W       = 6;
  localparam int LOCK_W      = 16;
  localparam int NUM_W       = 24;
  localparam int SPD_W       = 16;
  localparam int BHALF_W     = 3;
  localparam int IDX_W       = 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PULSE = 1'b1;

  localparam logic [IDX_W-1:0] REG_BRAKE_OFF  = 3'd0;
  localparam logic [IDX_W-1:0] REG_BRAKE_MID  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BRAKE_HIGH = 3'd2;
  localparam logic [IDX_W-1:0] REG_IND_HALF   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOCKOUT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_NUMERATOR  = 3'd5;

  localparam logic [THR_W-1:0]   BRAKE_OFF_RST  = 13'd757;
  localparam logic [THR_W-1:0]   BRAKE_MID_RST  = 13'd2103;
  localparam logic [THR_W-1:0]   BRAKE_HIGH_RST = 13'd2944;
  localparam logic [IND_W-1:0]   IND_HALF_RST   = 6'd8;
  localparam logic [LOCK_W-1:0]  LOCKOUT_RST    = 16'd100;
  localparam logic [NUM_W-1:0]   NUMERATOR_RST  = 24'd67824;

  localparam logic [BHALF_W-1:0] BRAKE_HALF_RST  = 3'd5;
  localparam logic [BHALF_W-1:0] BRAKE_COUNT_RST = 3'd4;
  localparam logic [IND_W-1:0]   IND_COUNT_RST   = 6'd4;

endpackage

`default_nettype wire

// ===== sv/brake_blink_and_wheel_speed_timer_top.sv =====
// channel | dir | handshake                   | payload
// in_     | in  | in_tvalid / in_tready       | tuser: mode; tdata: brake_sample, time_ms
// out_    | out | out_tvalid / out_tready     | tdata: speed, brake, left, right, pulse_seen
// cfg_    | in  | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A wheel pulse gives no word; in_tready stays high.
// A tick's word enters the output register when the bit-serial 24-step divider
// is done and the output register is free, so no new tick is taken before then;
// in_tready is low from the tick until its word enters the output register.
// A waiting output word holds back the next tick's result, and with it acceptance.
// Reset is synchronous, active low, with no clearing pass; cfg_ready is always high.
`default_nettype none

module brake_blink_and_wheel_speed_timer_top #(
  parameter int ADC_BITS = bbwst_pkg::ADC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [11:0] brake_sample, [43:12] time_ms, [47:44] zero
  input  wire logic [bbwst_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] mode
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [15:0] speed_tenths_kmh, [16] brake_light, [17] left_indicator,
  // [18] right_indicator, [19] pulse_seen, [23:20] zero
  output logic [bbwst_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bbwst_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [bbwst_pkg::NUM_W-1:0]         cfg_data
);

  localparam int SMP_W = (ADC_BITS < bbwst_pkg::SMP_FIELD_W) ? ADC_BITS
                                                             : bbwst_pkg::SMP_FIELD_W;
  localparam int THR_W = bbwst_pkg::THR_W;
  localparam int IND_W = bbwst_pkg::IND_W;
  localparam int TW    = bbwst_pkg::TIME_W;
  localparam int BW    = bbwst_pkg::BHALF_W;
  localparam int MCW   = $clog2(IND_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  function automatic logic [BW-1:0] brake_next(input logic [BW-1:0] half,
                                               input logic [BW-1:0] count);
    logic [BW-1:0] r;
    if (count == '0) begin
      r = half - BW'(1);
    end else begin
      r = count - BW'(1);
      for (int k = 0; k < 3; k++) begin
        if (r >= half) r = r - half;
      end
    end
    return r;
  endfunction

  logic [THR_W-1:0]              off_thr_r, mid_thr_r, high_thr_r;
  logic [IND_W-1:0]              ind_cfg_r;
  logic [bbwst_pkg::LOCK_W-1:0]  lockout_r;
  logic [bbwst_pkg::NUM_W-1:0]   numer_r;

  logic [BW-1:0]    bhalf_r, bhalf_nxt;
  logic [BW-1:0]    bcount_r, bcount_nxt;
  logic             blight_r, blight_nxt;
  logic [IND_W-1:0] icount_r, icount_nxt;
  logic             ion_r, ion_nxt;
  logic [TW-1:0]    last_r, last_nxt;
  logic [TW-1:0]    interval_r, interval_nxt;
  logic             seen_r, seen_nxt;

  logic [1:0]       state_r, state_nxt;
  logic [MCW-1:0]   mcnt_r, mcnt_nxt;
  logic [IND_W-1:0] mnum_r, mnum_nxt;
  logic [IND_W-1:0] mrem_r, mrem_nxt;
  logic [IND_W-1:0] mhalf_r, mhalf_nxt;
  logic             mzero_r, mzero_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [bbwst_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  logic                     in_acc, tick_acc, pulse_acc, cfg_acc;
  logic [THR_W-1:0]         sample;
  logic                     steady;
  logic [TW-1:0]            elapsed;
  logic [IND_W:0]           mrem_sh;
  logic [IND_W:0]           mdiff;
  logic                     load;
  logic                     div_done;
  logic [bbwst_pkg::SPD_W-1:0] speed;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && (in_tuser == bbwst_pkg::MODE_TICK);
  assign pulse_acc = in_acc && (in_tuser == bbwst_pkg::MODE_PULSE);
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign sample  = {{(THR_W - SMP_W){1'b0}}, in_tdata[SMP_W-1:0]};
  assign steady  = (sample < off_thr_r);
  assign elapsed = in_tdata[TW+bbwst_pkg::SMP_FIELD_W-1:bbwst_pkg::SMP_FIELD_W] - last_r;

  bbwst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tick_acc),
    .num   (numer_r),
    .den   (interval_r),
    .done  (div_done),
    .quot  (speed)
  );

  always_comb begin
    bhalf_nxt    = bhalf_r;
    bcount_nxt   = bcount_r;
    blight_nxt   = blight_r;
    ion_nxt      = ion_r;
    icount_nxt   = icount_r;
    last_nxt     = last_r;
    interval_nxt = interval_r;
    seen_nxt     = seen_r;
    mcnt_nxt     = mcnt_r;
    mnum_nxt     = mnum_r;
    mrem_nxt     = mrem_r;
    mhalf_nxt    = mhalf_r;
    mzero_nxt    = mzero_r;

    mrem_sh = {mrem_r, mnum_r[IND_W-1]};
    mdiff   = mrem_sh - {1'b0, mhalf_r};

    if (pulse_acc && (!seen_r || (elapsed >= TW'(lockout_r)))) begin
      interval_nxt = elapsed;
      last_nxt     = in_tdata[TW+bbwst_pkg::SMP_FIELD_W-1:bbwst_pkg::SMP_FIELD_W];
      seen_nxt     = 1'b1;
    end

    if (tick_acc) begin
      if (!steady) begin
        if (sample < mid_thr_r)       bhalf_nxt = BW'(3);
        else if (sample < high_thr_r) bhalf_nxt = BW'(2);
        else                          bhalf_nxt = BW'(1);
      end
      blight_nxt = steady ? 1'b1 : (blight_r ^ (bcount_r == '0));
      bcount_nxt = brake_next(bhalf_nxt, bcount_r);
      ion_nxt    = ion_r ^ (icount_r == '0);
      mhalf_nxt  = (ind_cfg_r == '0) ? IND_W'(1) : ind_cfg_r;
      mnum_nxt   = icount_r - IND_W'(1);
      mzero_nxt  = (icount_r == '0);
      mrem_nxt   = '0;
      mcnt_nxt   = MCW'(IND_W);
    end else if (mcnt_r != '0) begin
      mnum_nxt = {mnum_r[IND_W-2:0], 1'b0};
      mrem_nxt = (mrem_sh >= {1'b0, mhalf_r}) ? mdiff[IND_W-1:0] : mrem_sh[IND_W-1:0];
      mcnt_nxt = mcnt_r - MCW'(1);
      if (mcnt_r == MCW'(1)) begin
        icount_nxt = mzero_r ? (mhalf_r - IND_W'(1)) : mrem_nxt;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (div_done) begin
          if (!out_valid_r || out_tready) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, seen_r, ion_r, ion_r, blight_r, speed};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_thr_r   <= bbwst_pkg::BRAKE_OFF_RST;
      mid_thr_r   <= bbwst_pkg::BRAKE_MID_RST;
      high_thr_r  <= bbwst_pkg::BRAKE_HIGH_RST;
      ind_cfg_r   <= bbwst_pkg::IND_HALF_RST;
      lockout_r   <= bbwst_pkg::LOCKOUT_RST;
      numer_r     <= bbwst_pkg::NUMERATOR_RST;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        bbwst_pkg::REG_BRAKE_OFF:  off_thr_r  <= cfg_data[THR_W-1:0];
        bbwst_pkg::REG_BRAKE_MID:  mid_thr_r  <= cfg_data[THR_W-1:0];
        bbwst_pkg::REG_BRAKE_HIGH: high_thr_r <= cfg_data[THR_W-1:0];
        bbwst_pkg::REG_IND_HALF:   ind_cfg_r  <= cfg_data[IND_W-1:0];
        bbwst_pkg::REG_LOCKOUT:    lockout_r  <= cfg_data[bbwst_pkg::LOCK_W-1:0];
        bbwst_pkg::REG_NUMERATOR:  numer_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bhalf_r     <= bbwst_pkg::BRAKE_HALF_RST;
      bcount_r    <= bbwst_pkg::BRAKE_COUNT_RST;
      blight_r    <= 1'b0;
      icount_r    <= bbwst_pkg::IND_COUNT_RST;
      ion_r       <= 1'b0;
      last_r      <= '0;
      interval_r  <= '0;
      seen_r      <= 1'b0;
      state_r     <= ST_IDLE;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bhalf_r     <= bhalf_nxt;
      bcount_r    <= bcount_nxt;
      blight_r    <= blight_nxt;
      icount_r    <= icount_nxt;
      ion_r       <= ion_nxt;
      last_r      <= last_nxt;
      interval_r  <= interval_nxt;
      seen_r      <= seen_nxt;
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mnum_r     <= mnum_nxt;
    mrem_r     <= mrem_nxt;
    mhalf_r    <= mhalf_nxt;
    mzero_r    <= mzero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/bbwst_div.sv =====
`default_nettype none

module bbwst_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [bbwst_pkg::NUM_W-1:0]      num,
  input  wire logic [bbwst_pkg::TIME_W-1:0]     den,
  output logic                                  done,
  output logic [bbwst_pkg::SPD_W-1:0]           quot
);

  localparam int NW  = bbwst_pkg::NUM_W;
  localparam int DW  = bbwst_pkg::TIME_W;
  localparam int SW  = bbwst_pkg::SPD_W;
  localparam int CW  = $clog2(NW + 1);

  logic [NW-1:0] num_sh_r, num_sh_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          zero_r, zero_nxt;

  logic [NW:0]   rem_sh;
  logic [NW:0]   diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r, num_sh_r[NW-1]};
    ge     = (den[DW-1:NW+1] == '0) && (rem_sh >= den[NW:0]);
    diff   = rem_sh - den[NW:0];

    num_sh_nxt = num_sh_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    zero_nxt   = zero_r;

    if (start) begin
      num_sh_nxt = num;
      rem_nxt    = '0;
      quo_nxt    = '0;
      cnt_nxt    = CW'(NW);
      busy_nxt   = 1'b1;
      zero_nxt   = (den == '0);
    end else if (busy_r) begin
      num_sh_nxt = {num_sh_r[NW-2:0], 1'b0};
      rem_nxt    = ge ? diff[NW-1:0] : rem_sh[NW-1:0];
      quo_nxt    = {quo_r[NW-2:0], ge};
      cnt_nxt    = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_sh_r <= num_sh_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    zero_r   <= zero_nxt;
  end

  assign done = done_r;
  assign quot = (zero_r || (quo_r[NW-1:SW] != '0)) ? '1 : quo_r[SW-1:0];

endmodule

`default_nettype wire

// ===== sv/bbwst_chk.sv =====
`default_nettype none

module bbwst_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [bbwst_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_ind_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17] == out_tdata[18]))
    else $error("left and right indicators differ");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == bbwst_pkg::MODE_TICK) |=> !in_tready)
    else $error("input ready right after a tick");

  a_pulse_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == bbwst_pkg::MODE_PULSE) |=> in_tready)
    else $error("wheel pulse blocked the input");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind brake_blink_and_wheel_speed_timer_top bbwst_chk u_bbwst_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_brake_blink_and_wheel_speed_timer_top.sv =====
`timescale 1ns / 100ps

module tb_brake_blink_and_wheel_speed_timer_top;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          TAIL_CYCLES = 60;
  localparam int          CFG_GAP     = 40;

  localparam logic [bbwst_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bbwst_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                        pulse_seen;
    logic                        right_ind;
    logic                        left_ind;
    logic                        brake;
    logic [bbwst_pkg::SPD_W-1:0] speed;
  } dash_word_t;

  typedef struct packed {
    logic                              mode;
    logic [bbwst_pkg::SMP_FIELD_W-1:0] smp;
    logic [bbwst_pkg::TIME_W-1:0]      tm;
    logic                              fix;
    logic [bbwst_pkg::SPD_W-1:0]       spd;
  } dir_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [bbwst_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [bbwst_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [bbwst_pkg::IDX_W-1:0]      cfg_index;
  logic [bbwst_pkg::NUM_W-1:0]      cfg_data;

  brake_blink_and_wheel_speed_timer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor copy of the registers
  logic [bbwst_pkg::THR_W-1:0]   thr_off;
  logic [bbwst_pkg::THR_W-1:0]   thr_mid;
  logic [bbwst_pkg::THR_W-1:0]   thr_high;
  logic [bbwst_pkg::IND_W-1:0]   ind_half;
  logic [bbwst_pkg::LOCK_W-1:0]  lockout;
  logic [bbwst_pkg::NUM_W-1:0]   numer;

  // predictor copy of the state
  logic [bbwst_pkg::BHALF_W-1:0] bk_half;
  logic [bbwst_pkg::BHALF_W-1:0] bk_cnt;
  logic                          bk_on;
  logic [bbwst_pkg::IND_W-1:0]   ind_cnt;
  logic                          ind_on;
  logic [bbwst_pkg::TIME_W-1:0]  last_pulse_t;
  logic [bbwst_pkg::TIME_W-1:0]  interval;
  logic                          first_pending;
  logic                          seen;

  dash_word_t  dash_expected [$];
  dash_word_t  dash_want;
  logic [bbwst_pkg::TIME_W-1:0] stim_time;

  int unsigned cycle_cnt;
  int          err_cnt;
  int          words_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;

  dir_row_t dir_rows [25] = '{
    '{bbwst_pkg::MODE_TICK,  12'd0,    32'h5A5A_A5A5, 1'b1, 16'hFFFF},
    '{bbwst_pkg::MODE_TICK,  12'd4095, 32'hA5A5_5A5A, 1'b1, 16'hFFFF},
    '{bbwst_pkg::MODE_TICK,  12'd756,  32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd757,  32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2102, 32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2103, 32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2943, 32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2944, 32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_PULSE, 12'hABC,  32'd0,         1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd1000, 32'd0,         1'b1, 16'hFFFF},
    '{bbwst_pkg::MODE_PULSE, 12'h543,  32'd50,        1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2500, 32'd0,         1'b1, 16'hFFFF},
    '{bbwst_pkg::MODE_PULSE, 12'hFFF,  32'd100,       1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd3000, 32'd0,         1'b1, 16'd678},
    '{bbwst_pkg::MODE_PULSE, 12'h000,  32'd199,       1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd500,  32'd0,         1'b1, 16'd678},
    '{bbwst_pkg::MODE_PULSE, 12'h123,  32'hFFFF_FFFF, 1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2000, 32'd0,         1'b1, 16'd0},
    '{bbwst_pkg::MODE_PULSE, 12'h456,  32'd99,        1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd2200, 32'd0,         1'b1, 16'd678},
    '{bbwst_pkg::MODE_PULSE, 12'h789,  32'd100,       1'b0, 16'd0},
    '{bbwst_pkg::MODE_PULSE, 12'h9AB,  32'd67923,     1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd4000, 32'd0,         1'b1, 16'd1},
    '{bbwst_pkg::MODE_PULSE, 12'hCDE,  32'd203571,    1'b0, 16'd0},
    '{bbwst_pkg::MODE_TICK,  12'd1,    32'hFFFF_FFFF, 1'b1, 16'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at word %0d: %s got %0d want %0d", words_seen, what, got, want);
    err_cnt++;
  endtask

  function automatic void predict_item(input logic mode,
                                       input logic [bbwst_pkg::SMP_FIELD_W-1:0] smp,
                                       input logic [bbwst_pkg::TIME_W-1:0] tm,
                                       input logic fix,
                                       input logic [bbwst_pkg::SPD_W-1:0] spd);
    logic [bbwst_pkg::TIME_W-1:0] elapsed;
    logic [bbwst_pkg::TIME_W-1:0] quot;
    logic                         steady;
    int                           ih;
    dash_word_t                   w;
    if (mode == bbwst_pkg::MODE_PULSE) begin
      elapsed = tm - last_pulse_t;
      if (!(elapsed < {16'd0, lockout} && !first_pending)) begin
        interval      = elapsed;
        last_pulse_t  = tm;
        seen          = 1'b1;
        first_pending = 1'b0;
      end
    end else begin
      steady = 1'b0;
      if ({1'b0, smp} < thr_off) begin
        steady = 1'b1;
      end else if ({1'b0, smp} < thr_mid) begin
        bk_half = 3'd3;
      end else if ({1'b0, smp} < thr_high) begin
        bk_half = 3'd2;
      end else begin
        bk_half = 3'd1;
      end
      if (bk_cnt == 0) bk_on = ~bk_on;
      if (steady) bk_on = 1'b1;
      bk_cnt = bbwst_pkg::BHALF_W'((int'(bk_half) + int'(bk_cnt) - 1) % int'(bk_half));

      ih = (ind_half == 0) ? 1 : int'(ind_half);
      if (ind_cnt == 0) ind_on = ~ind_on;
      ind_cnt = bbwst_pkg::IND_W'((ih + int'(ind_cnt) - 1) % ih);

      if (interval == 0) begin
        w.speed = 16'hFFFF;
      end else begin
        quot = {8'd0, numer} / interval;
        w.speed = (quot > 32'hFFFF) ? 16'hFFFF : quot[bbwst_pkg::SPD_W-1:0];
      end
      if (fix) w.speed = spd;
      w.brake      = bk_on;
      w.left_ind   = ind_on;
      w.right_ind  = ind_on;
      w.pulse_seen = seen;
      dash_expected.push_back(w);
    end
  endfunction

  task automatic send_word(input logic mode, input logic [bbwst_pkg::SMP_FIELD_W-1:0] smp,
                           input logic [bbwst_pkg::TIME_W-1:0] tm, input logic fix,
                           input logic [bbwst_pkg::SPD_W-1:0] spd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'd0, tm, smp};
    do @(posedge clk); while (!in_tready);
    predict_item(mode, smp, tm, fix, spd);
    @(negedge clk);
  endtask

  task automatic drain_words();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (dash_expected.size() != 0);
  endtask

  task automatic cfg_write(input logic [bbwst_pkg::IDX_W-1:0] idx,
                           input logic [bbwst_pkg::NUM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bbwst_pkg::REG_BRAKE_OFF:  thr_off  = val[bbwst_pkg::THR_W-1:0];
      bbwst_pkg::REG_BRAKE_MID:  thr_mid  = val[bbwst_pkg::THR_W-1:0];
      bbwst_pkg::REG_BRAKE_HIGH: thr_high = val[bbwst_pkg::THR_W-1:0];
      bbwst_pkg::REG_IND_HALF:   ind_half = val[bbwst_pkg::IND_W-1:0];
      bbwst_pkg::REG_LOCKOUT:    lockout  = val[bbwst_pkg::LOCK_W-1:0];
      bbwst_pkg::REG_NUMERATOR:  numer    = val[bbwst_pkg::NUM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [bbwst_pkg::THR_W-1:0] off,
                               input logic [bbwst_pkg::THR_W-1:0] mid,
                               input logic [bbwst_pkg::THR_W-1:0] high,
                               input logic [bbwst_pkg::IND_W-1:0] ih,
                               input logic [bbwst_pkg::LOCK_W-1:0] lk,
                               input logic [bbwst_pkg::NUM_W-1:0] num,
                               input bit spare);
    drain_words();
    repeat (CFG_GAP) @(negedge clk);
    cfg_write(bbwst_pkg::REG_BRAKE_OFF, bbwst_pkg::NUM_W'(off));
    cfg_write(bbwst_pkg::REG_BRAKE_MID, bbwst_pkg::NUM_W'(mid));
    cfg_write(bbwst_pkg::REG_BRAKE_HIGH, bbwst_pkg::NUM_W'(high));
    cfg_write(bbwst_pkg::REG_IND_HALF, bbwst_pkg::NUM_W'(ih));
    cfg_write(bbwst_pkg::REG_LOCKOUT, bbwst_pkg::NUM_W'(lk));
    cfg_write(bbwst_pkg::REG_NUMERATOR, num);
    if (spare) begin
      cfg_write(REG_SPARE_LO, bbwst_pkg::NUM_W'($urandom));
      cfg_write(REG_SPARE_HI, bbwst_pkg::NUM_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_settings();
    int a;
    int b;
    int c;
    int t;
    logic [bbwst_pkg::LOCK_W-1:0] lk;
    logic [bbwst_pkg::NUM_W-1:0]  num;
    a = $urandom_range(4096);
    b = $urandom_range(4096);
    c = $urandom_range(4096);
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    lk  = ($urandom_range(99) < 70) ? bbwst_pkg::LOCK_W'($urandom_range(400))
                                    : bbwst_pkg::LOCK_W'($urandom);
    num = ($urandom_range(99) < 60) ? bbwst_pkg::NUM_W'($urandom_range(300000, 1000))
                                    : bbwst_pkg::NUM_W'($urandom);
    load_settings(bbwst_pkg::THR_W'(a), bbwst_pkg::THR_W'(b), bbwst_pkg::THR_W'(c),
                  bbwst_pkg::IND_W'($urandom_range(63, 1)), lk, num, 1'b0);
  endtask

  task automatic run_random(input int n, input int hold_at, input int pause_at);
    logic                              mode;
    logic [bbwst_pkg::SMP_FIELD_W-1:0] smp;
    logic [bbwst_pkg::TIME_W-1:0]      tm;
    int                                pick;
    int                                s;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_left = 600;
      if (i == pause_at) drain_words();
      mode = ($urandom_range(99) < 40) ? bbwst_pkg::MODE_PULSE : bbwst_pkg::MODE_TICK;
      smp  = bbwst_pkg::SMP_FIELD_W'($urandom);
      tm   = $urandom;
      if (mode == bbwst_pkg::MODE_TICK) begin
        if ($urandom_range(99) < 30) begin
          pick = $urandom_range(2);
          s = (pick == 0) ? int'(thr_off) : (pick == 1) ? int'(thr_mid) : int'(thr_high);
          s = s + $urandom_range(4) - 2;
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          smp = bbwst_pkg::SMP_FIELD_W'(s);
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          stim_time = stim_time + $urandom_range(int'(lockout));
        end else if (pick < 85) begin
          stim_time = stim_time + {16'd0, lockout} + $urandom_range(300);
        end else begin
          stim_time = $urandom;
        end
        tm = stim_time;
      end
      send_word(mode, smp, tm, 1'b0, 16'd0);
    end
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (dash_expected.size() == 0) begin
        note_mismatch("unexpected word", 32'(out_tdata), 32'd0);
      end else begin
        dash_want = dash_expected.pop_front();
        if (out_tdata[15:0] !== dash_want.speed)
          note_mismatch("speed_tenths_kmh", 32'(out_tdata[15:0]), 32'(dash_want.speed));
        if (out_tdata[16] !== dash_want.brake)
          note_mismatch("brake_light", 32'(out_tdata[16]), 32'(dash_want.brake));
        if (out_tdata[17] !== dash_want.left_ind)
          note_mismatch("left_indicator", 32'(out_tdata[17]), 32'(dash_want.left_ind));
        if (out_tdata[18] !== dash_want.right_ind)
          note_mismatch("right_indicator", 32'(out_tdata[18]), 32'(dash_want.right_ind));
        if (out_tdata[19] !== dash_want.pulse_seen)
          note_mismatch("pulse_seen", 32'(out_tdata[19]), 32'(dash_want.pulse_seen));
      end
      words_seen++;
    end
  end

  initial begin
    cycle_cnt     = 0;
    err_cnt       = 0;
    words_seen    = 0;
    hold_left     = 0;
    stim_time     = 0;
    send_idle_pct = 23;
    recv_idle_pct = 87;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = bbwst_pkg::MODE_TICK;
    cfg_valid     = 1'b0;
    cfg_index     = bbwst_pkg::REG_BRAKE_OFF;
    cfg_data      = '0;

    thr_off       = bbwst_pkg::BRAKE_OFF_RST;
    thr_mid       = bbwst_pkg::BRAKE_MID_RST;
    thr_high      = bbwst_pkg::BRAKE_HIGH_RST;
    ind_half      = bbwst_pkg::IND_HALF_RST;
    lockout       = bbwst_pkg::LOCKOUT_RST;
    numer         = bbwst_pkg::NUMERATOR_RST;
    bk_half       = bbwst_pkg::BRAKE_HALF_RST;
    bk_cnt        = bbwst_pkg::BRAKE_COUNT_RST;
    bk_on         = 1'b0;
    ind_cnt       = bbwst_pkg::IND_COUNT_RST;
    ind_on        = 1'b0;
    last_pulse_t  = '0;
    interval      = '0;
    first_pending = 1'b1;
    seen          = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].mode, dir_rows[i].smp, dir_rows[i].tm, dir_rows[i].fix,
                dir_rows[i].spd);
    stim_time = 32'd203571;

    load_settings(13'd0, 13'd4096, 13'd4096, 6'd1, 16'd0, 24'hFFFFFF, 1'b0);
    run_random(120, 60, -1);
    load_settings(13'd4096, 13'd0, 13'd0, 6'd63, 16'hFFFF, 24'd0, 1'b0);
    run_random(120, -1, -1);

    send_idle_pct = 87;
    recv_idle_pct = 23;
    load_settings(13'd3000, 13'd1000, 13'd2000, 6'd0,
                  bbwst_pkg::LOCK_W'($urandom_range(300)), bbwst_pkg::NUM_W'($urandom),
                  1'b1);
    run_random(120, -1, -1);

    for (int k = 0; k < 6; k++) begin
      if (k == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_random_settings();
      run_random(125, -1, (k == 1) ? 60 : -1);
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (dash_expected.size() != 0)
      note_mismatch("words never delivered", 32'(dash_expected.size()), 32'd0);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
